// ===== hdl/alid_pkg.sv =====
// Package for the array list block: opcodes, status codes, default sizes
// and the controller-to-datapath command struct. No dependencies.
`default_nettype none
package alid_pkg;

  localparam int CAPACITY_DEF   = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_ILLEGAL  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic load;  // capture the command on accepted transfer
    logic exec;  // apply the captured command to the list
  } ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/alid_ctrl.sv =====
// Controller of the array list: accept/execute state machine and result strobe.
// Depends on alid_pkg.
`default_nettype none
module alid_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               valid_o,
  output alid_pkg::ctrl_t    ctrl_o
);
  import alid_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q == S_EXEC);
  assign valid_o     = done_q;
  assign ctrl_o.load = start_i && (state_q == S_IDLE);
  assign ctrl_o.exec = (state_q == S_EXEC);

endmodule
`default_nettype wire

// ===== hdl/alid_datapath.sv =====
// Datapath of the array list: command latch, row of entry cells with shift
// and compare, entry count and result registers. Depends on alid_pkg.
`default_nettype none
module alid_datapath #(
  parameter int CAPACITY   = alid_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = alid_pkg::DATA_WIDTH_DEF,
  parameter int PosW       = $clog2(CAPACITY + 1),
  parameter int IdxW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire alid_pkg::ctrl_t        ctrl_i,
  input  wire logic [1:0]             opcode_i,
  input  wire logic [PosW-1:0]        position_i,
  input  wire logic [DATA_WIDTH-1:0]  value_i,
  output logic [2:0]                  status_o,
  output logic [IdxW-1:0]             found_position_o,
  output logic [PosW-1:0]             entry_count_o
);
  import alid_pkg::*;

  logic [1:0]            op_q;
  logic [PosW-1:0]       pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [DATA_WIDTH-1:0] entries_q [CAPACITY];
  logic [DATA_WIDTH-1:0] entries_d [CAPACITY];
  logic [PosW-1:0]       count_q, count_d;
  logic [2:0]            status_q, status_d;
  logic [IdxW-1:0]       found_q, found_d;
  logic [CAPACITY-1:0]   match;
  logic                  is_full, is_illegal, is_empty;

  assign is_full    = (count_q == PosW'(CAPACITY));
  assign is_illegal = (pos_q > count_q);
  assign is_empty   = (pos_q >= count_q);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (PosW'(i) < count_q) && (entries_q[i] == val_q);
    end
  end

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = ST_OK;
    found_d   = '0;
    case (op_q)
      OP_INSERT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else if (is_illegal) begin
          status_d = ST_ILLEGAL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (PosW'(i) == pos_q) begin
              entries_d[i] = val_q;
            end else if ((i > 0) && (PosW'(i) > pos_q)) begin
              entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (PosW'(i) >= pos_q) entries_d[i] = entries_q[i + 1];
          end
          count_d = count_q - 1'b1;
        end
      end
      OP_FIND: begin
        status_d = (|match) ? ST_OK : ST_NOTFOUND;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (match[i]) found_d = IdxW'(i);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (ctrl_i.exec) begin
      entries_q <= entries_d;
      status_q  <= status_d;
      found_q   <= found_d;
    end
  end

  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign entry_count_o    = count_q;

endmodule
`default_nettype wire

// ===== hdl/array_list_insert_delete_find.sv =====
// Top level of the array list: ties the controller to the datapath.
// Depends on alid_pkg, alid_ctrl and alid_datapath.
//
// Usage:
//   Command channel: an operation (opcode_i, position_i, value_i) transfers
//   at a rising edge where start_i is high and busy_o is low. Opcodes are
//   insert, delete and find; opcode 3 does nothing and reports ok.
//   Result channel: valid_o is high for exactly one cycle per operation,
//   carrying status_o, found_position_o and entry_count_o (count after the
//   operation). The receiver cannot stall; the result must be taken then.
// Timing:
//   The edge after the transfer applies the operation to the entry cells
//   (parallel shift and compare), valid_o follows in the next cycle.
//   busy_o is high for the one execute cycle, so no new operation is taken
//   while one executes; a new start may transfer during the valid_o cycle.
// Reset:
//   rst_ni clears the list to empty and idles the controller. Entry contents
//   are undefined until written; only entries below the count are read.
`default_nettype none
module array_list_insert_delete_find #(
  parameter int CAPACITY   = alid_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = alid_pkg::DATA_WIDTH_DEF,
  parameter int PosW       = $clog2(CAPACITY + 1),
  parameter int IdxW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [PosW-1:0]              position_i,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  output logic                              valid_o,
  output logic [2:0]                        status_o,
  output logic [IdxW-1:0]                   found_position_o,
  output logic [PosW-1:0]                   entry_count_o
);
  import alid_pkg::*;

  ctrl_t ctrl;

  alid_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .ctrl_o  (ctrl)
  );

  alid_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .PosW       (PosW),
    .IdxW       (IdxW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .opcode_i         (opcode_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

endmodule
`default_nettype wire

// ===== hdl/alid_checker.sv =====
// Port-level checker for the array list, bound to the top level.
// Depends on alid_pkg and array_list_insert_delete_find.
`default_nettype none
module alid_checker #(
  parameter int CAPACITY = alid_pkg::CAPACITY_DEF,
  parameter int PosW     = $clog2(CAPACITY + 1),
  parameter int IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start_i,
  input wire logic            busy_o,
  input wire logic            valid_o,
  input wire logic [2:0]      status_o,
  input wire logic [IdxW-1:0] found_position_o,
  input wire logic [PosW-1:0] entry_count_o
);
  import alid_pkg::*;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("transfer not followed by busy");

  a_busy_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o && !busy_o)
    else $error("execute cycle not followed by one result");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> entry_count_o <= PosW'(CAPACITY))
    else $error("entry count above capacity");

  a_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_OK) |-> found_position_o == '0)
    else $error("found position set on failed operation");

endmodule

bind array_list_insert_delete_find alid_checker #(
  .CAPACITY (CAPACITY),
  .PosW     (PosW),
  .IdxW     (IdxW)
) u_alid_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .valid_o          (valid_o),
  .status_o         (status_o),
  .found_position_o (found_position_o),
  .entry_count_o    (entry_count_o)
);
`default_nettype wire
